// ----- sv/ppc_pkg.sv -----
`default_nettype none
package ppc_pkg;

  // coordinate format
  localparam int FRAC_BITS  = 16;
  localparam int CW         = 24;
  localparam int IW         = 32;
  localparam int SHW        = CW - FRAC_BITS + 1;
  localparam int MAX_PIECES = 16;
  localparam int CNT_W      = $clog2(MAX_PIECES);

  // cut arithmetic widths
  localparam int BN_W  = FRAC_BITS;
  localparam int AD_W  = 26;
  localparam int PR_W  = BN_W + AD_W;
  localparam int NUM_W = PR_W + 2;
  localparam int DEN_W = AD_W + 1;
  localparam int Q_W   = AD_W + 1;

  typedef logic signed [IW-1:0] crd_t;

  localparam crd_t ONE       = crd_t'(1) <<< FRAC_BITS;
  localparam crd_t FRAC_MASK = ONE - crd_t'(1);
  localparam crd_t CRD_MAX   = (crd_t'(1) <<< (CW - 1)) - crd_t'(1);
  localparam crd_t CRD_MIN   = -(crd_t'(1) <<< (CW - 1));

  // one queued vertex word
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 first;
  } vtx_t;

  // queue control word driven by the front
  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MUL,
    S_DIV0,
    S_DIVW,
    S_EMITC,
    S_EMITL
  } bk_state_t;

  // saturate an internal coordinate to the port width
  function automatic logic signed [CW-1:0] sat_crd(input crd_t v);
    crd_t s;
    if (v > CRD_MAX) begin
      s = CRD_MAX;
    end else if (v < CRD_MIN) begin
      s = CRD_MIN;
    end else begin
      s = v;
    end
    return s[CW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/periodic_polyline_clipper.sv -----
`default_nettype none
// Periodic polyline clipper. Vertices in signed Q8.16 cell coordinates enter
// through a two-word queue; a line's first vertex is wrapped into the cell
// and produces no output. Every other vertex closes an edge and is cut at
// each cell boundary it crosses. A 27-step restoring divider places each
// cut point; pieces leave through a registered output, the last one marked,
// with at most 16 pieces per vertex. The periodic axis mask is written
// through cfg_wr_en and cfg_wr_data, and the user must write it only while
// the block is idle; the block itself does not enforce this. It resets to
// all three axes.
module periodic_polyline_clipper (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [2:0]                    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ppc_pkg::CW-1:0] in_vertex_x,
  input  wire logic signed [ppc_pkg::CW-1:0] in_vertex_y,
  input  wire logic signed [ppc_pkg::CW-1:0] in_vertex_z,
  input  wire logic                          in_line_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_start_x,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_start_y,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_start_z,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_end_x,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_end_y,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_end_z,
  output logic                               out_begins_fresh,
  output logic                               out_last_piece,
  output logic                               out_overflow
);

  ppc_pkg::q_ctl_t q_ctl;
  ppc_pkg::vtx_t   fw_word;
  ppc_pkg::vtx_t   bk_word;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  // front: accept and classify
  ppc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vertex_x   (in_vertex_x),
    .in_vertex_y   (in_vertex_y),
    .in_vertex_z   (in_vertex_z),
    .in_line_start (in_line_start),
    .q_full        (q_full),
    .q_ctl         (q_ctl),
    .q_word        (fw_word)
  );

  // decoupling queue
  ppc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_ctl.push),
    .wdata (fw_word),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (bk_word)
  );

  // back: clip edges and emit pieces
  ppc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .q_empty           (q_empty),
    .q_word            (bk_word),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_piece_start_x (out_piece_start_x),
    .out_piece_start_y (out_piece_start_y),
    .out_piece_start_z (out_piece_start_z),
    .out_piece_end_x   (out_piece_end_x),
    .out_piece_end_y   (out_piece_end_y),
    .out_piece_end_z   (out_piece_end_z),
    .out_begins_fresh  (out_begins_fresh),
    .out_last_piece    (out_last_piece),
    .out_overflow      (out_overflow)
  );

endmodule
`default_nettype wire

// ----- sv/ppc_queue.sv -----
`default_nettype none
module ppc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ppc_pkg::vtx_t wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output ppc_pkg::vtx_t      rdata
);

  ppc_pkg::vtx_t mem_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underrun");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ----- sv/ppc_front.sv -----
`default_nettype none
module ppc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ppc_pkg::CW-1:0] in_vertex_x,
  input  wire logic signed [ppc_pkg::CW-1:0] in_vertex_y,
  input  wire logic signed [ppc_pkg::CW-1:0] in_vertex_z,
  input  wire logic                          in_line_start,
  input  wire logic                          q_full,
  output ppc_pkg::q_ctl_t                    q_ctl,
  output ppc_pkg::vtx_t                      q_word
);

  logic have_prev_r, have_prev_nxt;

  // accept when the queue has room
  assign in_stall   = q_full;
  assign q_ctl.push = in_valid && !q_full;
  assign q_ctl.full = q_full;

  // classify: a word opens a line when flagged or when nothing came before
  always_comb begin
    q_word.x     = in_vertex_x;
    q_word.y     = in_vertex_y;
    q_word.z     = in_vertex_z;
    q_word.first = in_line_start || !have_prev_r;
    have_prev_nxt = have_prev_r || q_ctl.push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ppc_div.sv -----
`default_nettype none
module ppc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ppc_pkg::NUM_W-1:0]   num,
  input  wire logic [ppc_pkg::DEN_W-1:0]   den,
  output logic                             busy,
  output logic [ppc_pkg::Q_W-1:0]          quo
);

  localparam int CNT_DW = $clog2(ppc_pkg::Q_W + 1);

  logic [ppc_pkg::DEN_W-1:0] rem_r, rem_nxt;
  logic [ppc_pkg::DEN_W-1:0] den_r;
  logic [ppc_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [CNT_DW-1:0]         cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [ppc_pkg::DEN_W:0]   trial;
  logic                      ge;

  assign busy = busy_r;
  assign quo  = q_r;

  // one quotient bit a cycle, restoring
  always_comb begin
    trial    = {rem_r, q_r[ppc_pkg::Q_W-1]};
    ge       = (trial >= {1'b0, den_r});
    rem_nxt  = ge ? ppc_pkg::DEN_W'(trial - {1'b0, den_r})
                  : trial[ppc_pkg::DEN_W-1:0];
    q_nxt    = {q_r[ppc_pkg::Q_W-2:0], ge};
    cnt_nxt  = cnt_r - CNT_DW'(1);
    busy_nxt = (cnt_r != CNT_DW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_DW'(ppc_pkg::Q_W);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= ppc_pkg::DEN_W'(num[ppc_pkg::NUM_W-1:ppc_pkg::Q_W]);
      q_r   <= num[ppc_pkg::Q_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ppc_back.sv -----
`default_nettype none
module ppc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [2:0]                    cfg_wr_data,
  input  wire logic                          q_empty,
  input  wire ppc_pkg::vtx_t                 q_word,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_start_x,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_start_y,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_start_z,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_end_x,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_end_y,
  output logic signed [ppc_pkg::CW-1:0]      out_piece_end_z,
  output logic                               out_begins_fresh,
  output logic                               out_last_piece,
  output logic                               out_overflow
);

  ppc_pkg::bk_state_t st_r, st_nxt;

  logic [2:0]                   mask_r;
  logic signed [ppc_pkg::CW-1:0] prev_r  [3];
  logic signed [ppc_pkg::SHW-1:0] shift_r [3];
  logic                         next_fresh_r;
  ppc_pkg::crd_t                p1_r [3];
  ppc_pkg::crd_t                p2_r [3];
  logic                         fresh_r;
  logic [ppc_pkg::CNT_W-1:0]    n_r;
  logic [1:0]                   axis_r;
  logic                         found_r;
  logic [1:0]                   best_r;
  logic [ppc_pkg::BN_W-1:0]     bn_r;
  logic [ppc_pkg::AD_W-1:0]     bd_r;
  ppc_pkg::crd_t                tgt_r;
  logic                         up_r;
  logic                         ovf_r;
  logic [ppc_pkg::NUM_W-1:0]    dnum_r [3];

  logic signed [ppc_pkg::CW-1:0] ps_r [3];
  logic signed [ppc_pkg::CW-1:0] pe_r [3];
  logic                         ov_r, fr_r, lp_r, oval_r;

  // per-axis candidate wires
  ppc_pkg::crd_t            tgt_c [3];
  ppc_pkg::crd_t            dl_c  [3];
  logic                     ok_c  [3];
  logic                     up_c  [3];
  logic [ppc_pkg::BN_W-1:0] an_c  [3];
  logic [ppc_pkg::AD_W-1:0] ad_c  [3];
  logic [ppc_pkg::Q_W-1:0]  quo   [3];
  ppc_pkg::crd_t            x_c   [3];
  ppc_pkg::crd_t            p2_in [3];
  logic                     div_busy [3];

  logic                     out_free;
  logic                     div_start;
  logic                     out_load;
  logic [ppc_pkg::PR_W-1:0] lhs, rhs;
  logic                     take;

  assign out_free = !oval_r || !out_stall;

  // boundary candidates along every axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ppc_pkg::crd_t num_v;
      ppc_pkg::crd_t mag_n;
      ppc_pkg::crd_t mag_d;
      ppc_pkg::crd_t f1;
      ppc_pkg::crd_t f2;
      f1        = p1_r[i] >>> ppc_pkg::FRAC_BITS;
      f2        = p2_r[i] >>> ppc_pkg::FRAC_BITS;
      up_c[i]   = (f2 > f1);
      tgt_c[i]  = up_c[i] ? ((p1_r[i] + ppc_pkg::FRAC_MASK) & ~ppc_pkg::FRAC_MASK)
                          : (p1_r[i] & ~ppc_pkg::FRAC_MASK);
      num_v     = tgt_c[i] - p1_r[i];
      ok_c[i]   = mask_r[i] && (f1 != f2) && (num_v != '0);
      mag_n     = (num_v < 0) ? -num_v : num_v;
      an_c[i]   = mag_n[ppc_pkg::BN_W-1:0];
      dl_c[i]   = p2_r[i] - p1_r[i];
      mag_d     = (dl_c[i] < 0) ? -dl_c[i] : dl_c[i];
      ad_c[i]   = mag_d[ppc_pkg::AD_W-1:0];
    end
  end

  // exact compare of the scanned axis against the best so far
  always_comb begin
    lhs  = ppc_pkg::PR_W'(an_c[axis_r]) * ppc_pkg::PR_W'(bd_r);
    rhs  = ppc_pkg::PR_W'(bn_r) * ppc_pkg::PR_W'(ad_c[axis_r]);
    take = ok_c[axis_r] && (!found_r || (lhs < rhs));
  end

  // cut point and shifted end point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ppc_pkg::crd_t qv;
      ppc_pkg::crd_t sh;
      qv = ppc_pkg::crd_t'(quo[i]);
      if (best_r == 2'(i)) begin
        x_c[i] = tgt_r;
      end else begin
        x_c[i] = p1_r[i] + ((dl_c[i] < 0) ? -qv : qv);
      end
      sh       = ppc_pkg::crd_t'(shift_r[i]) <<< ppc_pkg::FRAC_BITS;
      p2_in[i] = ppc_pkg::crd_t'(ppc_pkg::sat_crd(
                   ppc_pkg::crd_t'(i == 0 ? q_word.x : (i == 1 ? q_word.y : q_word.z)) + sh));
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ppc_pkg::S_IDLE: begin
        if (!q_empty && !q_word.first) begin
          st_nxt = ppc_pkg::S_SCAN;
        end
      end
      ppc_pkg::S_SCAN: begin
        if (axis_r == 2'd2) begin
          st_nxt = ppc_pkg::S_DECIDE;
        end
      end
      ppc_pkg::S_DECIDE: begin
        if (!found_r || (n_r == ppc_pkg::CNT_W'(ppc_pkg::MAX_PIECES - 1))) begin
          st_nxt = ppc_pkg::S_EMITL;
        end else begin
          st_nxt = ppc_pkg::S_MUL;
        end
      end
      ppc_pkg::S_MUL:  st_nxt = ppc_pkg::S_DIV0;
      ppc_pkg::S_DIV0: st_nxt = ppc_pkg::S_DIVW;
      ppc_pkg::S_DIVW: begin
        if (!div_busy[0]) begin
          st_nxt = ppc_pkg::S_EMITC;
        end
      end
      ppc_pkg::S_EMITC: begin
        if (out_free) begin
          st_nxt = ppc_pkg::S_SCAN;
        end
      end
      ppc_pkg::S_EMITL: begin
        if (out_free) begin
          st_nxt = ppc_pkg::S_IDLE;
        end
      end
      default: st_nxt = ppc_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = (st_r == ppc_pkg::S_IDLE) && !q_empty;
    div_start = (st_r == ppc_pkg::S_DIV0);
    out_load  = ((st_r == ppc_pkg::S_EMITC) || (st_r == ppc_pkg::S_EMITL)) && out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ppc_pkg::S_IDLE;
      mask_r       <= 3'b111;
      next_fresh_r <= 1'b1;
      oval_r       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i]  <= '0;
        shift_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
      if (out_load) begin
        oval_r <= 1'b1;
      end else if (!out_stall) begin
        oval_r <= 1'b0;
      end
      // line opening word: wrap into the cell
      if (q_pop && q_word.first) begin
        next_fresh_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          logic signed [ppc_pkg::CW-1:0] v;
          v = (i == 0) ? q_word.x : ((i == 1) ? q_word.y : q_word.z);
          if (mask_r[i]) begin
            prev_r[i]  <= ppc_pkg::CW'({1'b0, v[ppc_pkg::FRAC_BITS-1:0]});
            shift_r[i] <= -ppc_pkg::SHW'($signed(v[ppc_pkg::CW-1:ppc_pkg::FRAC_BITS]));
          end else begin
            prev_r[i]  <= v;
            shift_r[i] <= '0;
          end
        end
      end
      // a cut moves the shift back by one cell
      if (st_r == ppc_pkg::S_EMITC && out_free) begin
        for (int i = 0; i < 3; i++) begin
          if (best_r == 2'(i)) begin
            shift_r[i] <= up_r ? shift_r[i] - ppc_pkg::SHW'(1) : shift_r[i] + ppc_pkg::SHW'(1);
          end
        end
      end
      // final piece stores the end point
      if (st_r == ppc_pkg::S_EMITL && out_free) begin
        next_fresh_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          prev_r[i] <= ppc_pkg::sat_crd(p2_r[i]);
        end
      end
    end
  end

  // edge datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      axis_r  <= '0;
      found_r <= 1'b0;
    end else begin
      unique case (st_r)
        ppc_pkg::S_IDLE: begin
          if (q_pop && !q_word.first) begin
            for (int i = 0; i < 3; i++) begin
              p1_r[i] <= ppc_pkg::crd_t'(prev_r[i]);
              p2_r[i] <= p2_in[i];
            end
            fresh_r <= next_fresh_r;
            n_r     <= '0;
            axis_r  <= '0;
            found_r <= 1'b0;
          end
        end
        ppc_pkg::S_SCAN: begin
          if (take) begin
            found_r <= 1'b1;
            best_r  <= axis_r;
            bn_r    <= an_c[axis_r];
            bd_r    <= ad_c[axis_r];
            tgt_r   <= tgt_c[axis_r];
            up_r    <= up_c[axis_r];
          end
          axis_r <= axis_r + 2'd1;
        end
        ppc_pkg::S_DECIDE: begin
          ovf_r <= found_r;
        end
        ppc_pkg::S_MUL: begin
          for (int i = 0; i < 3; i++) begin
            dnum_r[i] <= {ppc_pkg::PR_W'(bn_r) * ppc_pkg::PR_W'(ad_c[i]), 1'b0}
                         + ppc_pkg::NUM_W'(bd_r);
          end
        end
        ppc_pkg::S_EMITC: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) begin
              if (best_r == 2'(i)) begin
                p1_r[i] <= up_r ? x_c[i] - ppc_pkg::ONE : x_c[i] + ppc_pkg::ONE;
                p2_r[i] <= up_r ? p2_r[i] - ppc_pkg::ONE : p2_r[i] + ppc_pkg::ONE;
              end else begin
                p1_r[i] <= x_c[i];
              end
            end
            fresh_r <= 1'b1;
            n_r     <= n_r + ppc_pkg::CNT_W'(1);
            axis_r  <= '0;
            found_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        ps_r[i] <= p1_r[i][ppc_pkg::CW-1:0];
        pe_r[i] <= (st_r == ppc_pkg::S_EMITC) ? x_c[i][ppc_pkg::CW-1:0]
                                               : p2_r[i][ppc_pkg::CW-1:0];
      end
      fr_r <= fresh_r;
      lp_r <= (st_r == ppc_pkg::S_EMITL);
      ov_r <= (st_r == ppc_pkg::S_EMITL) && ovf_r;
    end
  end

  // one divider per axis, the cut axis result is unused
  for (genvar g = 0; g < 3; g++) begin : g_div
    ppc_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (dnum_r[g]),
      .den   ({bd_r, 1'b0}),
      .busy  (div_busy[g]),
      .quo   (quo[g])
    );
  end

  assign out_valid         = oval_r;
  assign out_piece_start_x = ps_r[0];
  assign out_piece_start_y = ps_r[1];
  assign out_piece_start_z = ps_r[2];
  assign out_piece_end_x   = pe_r[0];
  assign out_piece_end_y   = pe_r[1];
  assign out_piece_end_z   = pe_r[2];
  assign out_begins_fresh  = fr_r;
  assign out_last_piece    = lp_r;
  assign out_overflow      = ov_r;

`ifndef NO_ASSERTIONS
  a_piece_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ppc_pkg::S_EMITC) |-> (n_r < ppc_pkg::CNT_W'(ppc_pkg::MAX_PIECES - 1)))
    else $error("cut emitted beyond piece limit");
  a_ovf_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !lp_r) |-> !ov_r) else $error("overflow on a non-final piece");
  a_cut_axis_periodic: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ppc_pkg::S_MUL) |-> (found_r && mask_r[best_r]))
    else $error("cut on a non-periodic axis");
  a_div_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ppc_pkg::S_DIV0) |=> div_busy[0]) else $error("divider did not start");
`endif

endmodule
`default_nettype wire

// ----- dv/periodic_polyline_clipper_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module periodic_polyline_clipper_test;

  localparam int PIECE_LIMIT = 16;
  localparam longint CELL = 64'sd1 << 16;
  localparam longint FLOOR_BIAS = 64'sd1 << 50;

  typedef struct packed {
    logic signed [23:0] sx, sy, sz, ex, ey, ez;
    logic fresh, last, ovf;
  } piece_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_vertex_x = '0, in_vertex_y = '0, in_vertex_z = '0;
  logic in_line_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] out_piece_start_x, out_piece_start_y, out_piece_start_z;
  logic signed [23:0] out_piece_end_x, out_piece_end_y, out_piece_end_z;
  logic out_begins_fresh, out_last_piece, out_overflow;

  periodic_polyline_clipper u_top (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_vertex_x(in_vertex_x),
    .in_vertex_y(in_vertex_y), .in_vertex_z(in_vertex_z),
    .in_line_start(in_line_start), .out_valid(out_valid), .out_stall(out_stall),
    .out_piece_start_x(out_piece_start_x), .out_piece_start_y(out_piece_start_y),
    .out_piece_start_z(out_piece_start_z), .out_piece_end_x(out_piece_end_x),
    .out_piece_end_y(out_piece_end_y), .out_piece_end_z(out_piece_end_z),
    .out_begins_fresh(out_begins_fresh), .out_last_piece(out_last_piece),
    .out_overflow(out_overflow)
  );

  // clipper state mirror
  logic [2:0] axis_mask = 3'd7;
  longint end_pt [3];
  longint shift_cells [3];
  bit have_end = 0;
  bit fresh_next = 1;

  piece_t pieces_due [$];
  int fail_count = 0;
  bit hold_off = 0;
  int burst_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint cell_floor(longint v);
    return ((v + FLOOR_BIAS) >>> 16) - (FLOOR_BIAS >>> 16);
  endfunction

  function automatic longint wrap9(longint v);
    logic signed [8:0] s;
    s = v[8:0];
    return s;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic piece_t make_piece(longint a[3], longint b[3], bit f, bit l, bit o);
    piece_t p;
    p.sx = a[0][23:0]; p.sy = a[1][23:0]; p.sz = a[2][23:0];
    p.ex = b[0][23:0]; p.ey = b[1][23:0]; p.ez = b[2][23:0];
    p.fresh = f; p.last = l; p.ovf = o;
    return p;
  endfunction

  // add one predicted word at the tail
  task automatic expect_piece(piece_t p);
    pieces_due.insert(pieces_due.size(), p);
  endtask

  // predict the pieces one vertex word produces
  task automatic clip_vertex(logic signed [23:0] vx, vy, vz, bit start);
    longint v[3], a[3], b[3], c[3];
    longint k, f1, f2, tgt, dir, num, an, ad, bn, bd, btgt, bdir, dl, q;
    int best, n;
    bit fr, ovf;
    v[0] = vx; v[1] = vy; v[2] = vz;
    if (start || !have_end) begin
      for (int i = 0; i < 3; i++) begin
        if (axis_mask[i]) begin
          k = cell_floor(v[i]);
          end_pt[i] = v[i] - k * CELL;
          shift_cells[i] = wrap9(-k);
        end else begin
          end_pt[i] = v[i];
          shift_cells[i] = 0;
        end
      end
      have_end = 1;
      fresh_next = 1;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      a[i] = end_pt[i];
      b[i] = sat24(v[i] + shift_cells[i] * CELL);
    end
    fr = fresh_next;
    ovf = 0;
    n = 0;
    forever begin
      best = -1; bn = 0; bd = 1; btgt = 0; bdir = 0;
      for (int i = 0; i < 3; i++) begin
        if (!axis_mask[i]) continue;
        f1 = cell_floor(a[i]);
        f2 = cell_floor(b[i]);
        if (f1 == f2) continue;
        if (f2 > f1) begin
          tgt = -cell_floor(-a[i]) * CELL; dir = 1;
        end else begin
          tgt = f1 * CELL; dir = -1;
        end
        num = tgt - a[i];
        if (num == 0) continue;
        an = absval(num);
        ad = absval(b[i] - a[i]);
        if (best < 0 || an * bd < bn * ad) begin
          best = i; bn = an; bd = ad; btgt = tgt; bdir = dir;
        end
      end
      if (best < 0) break;
      if (n >= PIECE_LIMIT - 1) begin
        ovf = 1;
        break;
      end
      for (int i = 0; i < 3; i++) begin
        if (i == best) begin
          c[i] = btgt;
        end else begin
          dl = b[i] - a[i];
          q = (2 * bn * absval(dl) + bd) / (2 * bd);
          c[i] = a[i] + (dl < 0 ? -q : q);
        end
      end
      expect_piece(make_piece(a, c, fr, 0, 0));
      n++;
      shift_cells[best] = wrap9(shift_cells[best] - bdir);
      for (int i = 0; i < 3; i++) a[i] = c[i];
      a[best] -= bdir * CELL;
      b[best] -= bdir * CELL;
      fr = 1;
    end
    expect_piece(make_piece(a, b, fr, 1, ovf));
    for (int i = 0; i < 3; i++) end_pt[i] = sat24(b[i]);
    fresh_next = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // compare each accepted piece word with the oldest prediction
  always @(posedge clk) begin
    piece_t exp_p;
    if (rst_n && out_valid && !out_stall) begin
      if (pieces_due.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        exp_p = pieces_due.pop_front();
        if (out_piece_start_x !== exp_p.sx) report_mismatch("start_x", out_piece_start_x, exp_p.sx);
        if (out_piece_start_y !== exp_p.sy) report_mismatch("start_y", out_piece_start_y, exp_p.sy);
        if (out_piece_start_z !== exp_p.sz) report_mismatch("start_z", out_piece_start_z, exp_p.sz);
        if (out_piece_end_x !== exp_p.ex) report_mismatch("end_x", out_piece_end_x, exp_p.ex);
        if (out_piece_end_y !== exp_p.ey) report_mismatch("end_y", out_piece_end_y, exp_p.ey);
        if (out_piece_end_z !== exp_p.ez) report_mismatch("end_z", out_piece_end_z, exp_p.ez);
        if (out_begins_fresh !== exp_p.fresh)
          report_mismatch("begins_fresh", out_begins_fresh, exp_p.fresh);
        if (out_last_piece !== exp_p.last)
          report_mismatch("last_piece", out_last_piece, exp_p.last);
        if (out_overflow !== exp_p.ovf) report_mismatch("overflow", out_overflow, exp_p.ovf);
      end
    end
  end

  // receiver stall pattern, with a forced long hold-off when asked
  always @(posedge clk) begin
    int phase;
    phase = $urandom_range(0, 15);
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= (phase < 5) && ($realtime > 3000.0 || phase < 2);
  end

  // send one vertex word, with bursty random gaps
  task automatic send_vertex(logic signed [23:0] vx, vy, vz, bit start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_vertex_x <= vx; in_vertex_y <= vy; in_vertex_z <= vz;
    in_line_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clip_vertex(vx, vy, vz, start);
  endtask

  task automatic drain_and_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pieces_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic set_mask(logic [2:0] m);
    drain_and_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    axis_mask = m;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(0, 8 * 65536))) - 24'sd262144;
      2: return 24'($urandom_range(0, 65535));
      default: return ($signed(24'($urandom_range(0, 6))) - 24'sd3) <<< 16;
    endcase
  endfunction

  task automatic test_directed();
    send_vertex(24'sh000000, 24'sh000000, 24'sh000000, 1'b1);
    send_vertex(24'sh018000, 24'sh008000, 24'sh000000, 1'b0);
    send_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_vertex(-24'sh800000, -24'sh800000, -24'sh800000, 1'b0);
    send_vertex(-24'sh800000, 24'sh7FFFFF, 24'sh000001, 1'b1);
    send_vertex(24'sh7FFFFF, -24'sh800000, -24'sh000001, 1'b0);
    send_vertex(24'sh010000, 24'sh010000, 24'sh010000, 1'b1);
    send_vertex(24'sh020000, 24'sh020000, 24'sh020000, 1'b0);
    send_vertex(24'sh008000, 24'sh000000, 24'sh000000, 1'b1);
    send_vertex(24'sh108000, 24'sh0A0000, 24'sh050000, 1'b0);
    send_vertex(-24'sh100000, -24'sh030000, 24'sh001234, 1'b0);
    send_vertex(24'sh000000, 24'sh000000, 24'sh000000, 1'b0);
  endtask

  task automatic test_mask_settings();
    logic [2:0] m [4] = '{3'd0, 3'd1, 3'd6, 3'd7};
    foreach (m[j]) begin
      set_mask(m[j]);
      send_vertex(24'sh00C000, -24'sh004000, 24'sh01F000, 1'b1);
      send_vertex(24'sh034000, 24'sh024000, -24'sh018000, 1'b0);
      send_vertex(-24'sh7FFFFF, 24'sh7FFFFF, 24'sh000000, 1'b0);
    end
  endtask

  task automatic test_random_lines();
    for (int n = 0; n < 180; n++) begin
      if (n % 60 == 59) set_mask(3'($urandom_range(0, 7)));
      send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_vertex(24'sh000000, 24'sh000000, 24'sh000000, 1'b1);
        for (int n = 0; n < 12; n++)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0);
      end
    join
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_mask_settings();
    test_backpressure();
    test_random_lines();
    set_mask(3'd7);
    drain_and_idle();
    if (fail_count == 0 && pieces_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
